FILE: src/scaled_matrix_to_quaternion_defines.svh
// Assertion macros shared by the quaternion converter RTL.
`ifndef SCALED_MATRIX_TO_QUATERNION_DEFINES_SVH
`define SCALED_MATRIX_TO_QUATERNION_DEFINES_SVH

// Antecedent implies consequent in the same cycle; needs clk and rst_n in scope.
`define SMQ_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never be seen outside reset.
`define SMQ_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: src/smq_pkg.sv
// Types and fixed-point constants for the matrix to quaternion converter.
package smq_pkg;

    // Field width of elements and quaternion parts
    localparam int DATA_W   = 32;
    // Ratio r = elem / scale: Q.30, magnitude capped just under 4.0
    localparam int RFRAC    = 30;
    localparam int RATIO_W  = 32;
    localparam int SR_W     = RATIO_W + 2;
    // Sum or difference of two ratios
    localparam int NUM_W    = SR_W;
    // Trace and branch arguments
    localparam int ARG_W    = SR_W + 2;
    // Square root unit: 64-bit radicand, 32-bit root
    localparam int SQ_X_W   = 64;
    localparam int ROOT_W   = SQ_X_W / 2;
    localparam int SQ_REM_W = ROOT_W + 3;
    localparam int ARG_MAG_W = SQ_X_W - RFRAC;
    // Part numerator scaling: (num * 2^29) / root
    localparam int PFRAC    = 29;

    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } smq_branch_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] elem_r0c0;
        logic signed [DATA_W-1:0] elem_r0c1;
        logic signed [DATA_W-1:0] elem_r0c2;
        logic signed [DATA_W-1:0] elem_r1c0;
        logic signed [DATA_W-1:0] elem_r1c1;
        logic signed [DATA_W-1:0] elem_r1c2;
        logic signed [DATA_W-1:0] elem_r2c0;
        logic signed [DATA_W-1:0] elem_r2c1;
        logic signed [DATA_W-1:0] elem_r2c2;
        logic [DATA_W-2:0]        scale_col0;
        logic [DATA_W-2:0]        scale_col1;
        logic [DATA_W-2:0]        scale_col2;
    } smq_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic                     fault;
    } smq_out_t;

    // Sideband that rides along the square root cells
    typedef struct packed {
        logic                    fault;
        smq_branch_t             branch;
        logic signed [NUM_W-1:0] n0;
        logic signed [NUM_W-1:0] n1;
        logic signed [NUM_W-1:0] n2;
    } smq_sq_tag_t;

    // Sideband that rides beside the part dividers
    typedef struct packed {
        logic              fault;
        smq_branch_t       branch;
        logic [ROOT_W-2:0] half;
    } smq_pd_meta_t;

endpackage

FILE: src/smq_div_cell.sv
// One restoring division step: shift in a numerator bit, compare, subtract.
module smq_div_cell #(
    parameter int DW    = 32,
    parameter int QW    = 32,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic [DW-1:0]    rem_in,
    input  logic [DW-1:0]    den_in,
    input  logic [QW-1:0]    low_in,
    input  logic [QW-1:0]    quo_in,
    input  logic             ovf_in,
    input  logic [TAG_W-1:0] tag_in,
    output logic [DW-1:0]    rem_out,
    output logic [DW-1:0]    den_out,
    output logic [QW-1:0]    low_out,
    output logic [QW-1:0]    quo_out,
    output logic             ovf_out,
    output logic [TAG_W-1:0] tag_out
);

    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             ge;
    logic [DW-1:0]    rem_next, rem_reg;
    logic [DW-1:0]    den_reg;
    logic [QW-1:0]    low_next, low_reg;
    logic [QW-1:0]    quo_next, quo_reg;
    logic             ovf_reg;
    logic [TAG_W-1:0] tag_reg;

    // trial subtract; partial remainder stays below the divisor
    always_comb
    begin
        rem_sh   = {rem_in, low_in[QW-1]};
        diff     = rem_sh - {1'b0, den_in};
        ge       = (rem_sh >= {1'b0, den_in});
        rem_next = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        quo_next = {quo_in[QW-2:0], ge};
        low_next = {low_in[QW-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_in;
        low_reg <= low_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_in;
        tag_reg <= tag_in;
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign low_out = low_reg;
    assign quo_out = quo_reg;
    assign ovf_out = ovf_reg;
    assign tag_out = tag_reg;

endmodule

FILE: src/smq_divider.sv
// Pipelined unsigned divider: a row of step cells, quotient capped at all ones.
module smq_divider #(
    parameter int NW    = 62,
    parameter int DW    = 32,
    parameter int QW    = 32,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic [NW-1:0]    num,
    input  logic [DW-1:0]    den,
    input  logic [TAG_W-1:0] tag_in,
    output logic [QW-1:0]    quo,
    output logic [TAG_W-1:0] tag_out
);

    localparam int CW = (NW > DW) ? NW : DW;

    logic [CW-1:0]    hi_ext;
    logic [CW-1:0]    den_ext;
    logic             ovf_next;
    logic [DW-1:0]    rem0_next;

    logic [DW-1:0]    rem_s [0:QW];
    logic [DW-1:0]    den_s [0:QW];
    logic [QW-1:0]    low_s [0:QW];
    logic [QW-1:0]    quo_s [0:QW];
    logic             ovf_s [0:QW];
    logic [TAG_W-1:0] tag_s [0:QW];

    logic [DW-1:0]    rem0_reg;
    logic [DW-1:0]    den0_reg;
    logic [QW-1:0]    low0_reg;
    logic             ovf0_reg;
    logic [TAG_W-1:0] tag0_reg;

    // entry: quotient would not fit when the high part reaches the divisor
    always_comb
    begin
        hi_ext    = CW'(num >> QW);
        den_ext   = CW'(den);
        ovf_next  = (hi_ext >= den_ext);
        rem0_next = DW'(num >> QW);
    end

    always_ff @(posedge clk)
    begin
        rem0_reg <= rem0_next;
        den0_reg <= den;
        low0_reg <= num[QW-1:0];
        ovf0_reg <= ovf_next;
        tag0_reg <= tag_in;
    end

    assign rem_s[0] = rem0_reg;
    assign den_s[0] = den0_reg;
    assign low_s[0] = low0_reg;
    assign quo_s[0] = '0;
    assign ovf_s[0] = ovf0_reg;
    assign tag_s[0] = tag0_reg;

    // one quotient bit per cell
    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        smq_div_cell #(
            .DW    (DW),
            .QW    (QW),
            .TAG_W (TAG_W)
        ) u_cell (
            .clk     (clk),
            .rem_in  (rem_s[i]),
            .den_in  (den_s[i]),
            .low_in  (low_s[i]),
            .quo_in  (quo_s[i]),
            .ovf_in  (ovf_s[i]),
            .tag_in  (tag_s[i]),
            .rem_out (rem_s[i+1]),
            .den_out (den_s[i+1]),
            .low_out (low_s[i+1]),
            .quo_out (quo_s[i+1]),
            .ovf_out (ovf_s[i+1]),
            .tag_out (tag_s[i+1])
        );
    end

    assign quo     = ovf_s[QW] ? '1 : quo_s[QW];
    assign tag_out = tag_s[QW];

endmodule

FILE: src/smq_sqrt_cell.sv
// One digit step of the integer square root: two radicand bits per cell.
module smq_sqrt_cell #(
    parameter int TAG_W = 1
) (
    input  logic                       clk,
    input  logic [smq_pkg::SQ_X_W-1:0]   x_in,
    input  logic [smq_pkg::SQ_REM_W-1:0] rem_in,
    input  logic [smq_pkg::ROOT_W-1:0]   root_in,
    input  logic [TAG_W-1:0]           tag_in,
    output logic [smq_pkg::SQ_X_W-1:0]   x_out,
    output logic [smq_pkg::SQ_REM_W-1:0] rem_out,
    output logic [smq_pkg::ROOT_W-1:0]   root_out,
    output logic [TAG_W-1:0]           tag_out
);

    import smq_pkg::*;

    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;
    logic [SQ_REM_W-1:0] rem_next, rem_reg;
    logic [ROOT_W-1:0]   root_next, root_reg;
    logic [SQ_X_W-1:0]   x_next, x_reg;
    logic [TAG_W-1:0]    tag_reg;

    // bring down two bits, try 4*root + 1
    always_comb
    begin
        rem_sh    = {rem_in[SQ_REM_W-3:0], x_in[SQ_X_W-1 -: 2]};
        trial     = SQ_REM_W'({root_in, 2'b01});
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[ROOT_W-2:0], ge};
        x_next    = {x_in[SQ_X_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        x_reg    <= x_next;
        tag_reg  <= tag_in;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign x_out    = x_reg;
    assign tag_out  = tag_reg;

endmodule

FILE: src/scaled_matrix_to_quaternion.sv
// Top level: column-scaled 3x3 matrix to unit quaternion, Shepperd branches.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  input    | start, busy (always 0)| item   (smq_in_t)
//  result   | done strobe           | result (smq_out_t)
//
// One item is taken every cycle; each result passes in order through the nine
// ratio dividers, the trace and branch registers (B1..B3), the square root
// cells, the part dividers and the output register.
// Reset clears only the valid bits of the pipeline; results in flight are lost.
// The result is shown for one cycle with done; nothing downstream can stall it.
`include "scaled_matrix_to_quaternion_defines.svh"

module scaled_matrix_to_quaternion (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  smq_pkg::smq_in_t  item,
    output logic              done,
    output smq_pkg::smq_out_t result
);

    import smq_pkg::*;

    localparam int W       = DATA_W;
    localparam int RAT_NW  = W + RFRAC;
    localparam int RAT_LAT = RATIO_W + 1;
    localparam int PD_NW   = (NUM_W - 1) + PFRAC;
    localparam int SQ_TW   = $bits(smq_sq_tag_t);

    localparam logic [W-1:0] HI       = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SIGN_MAG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_SAT  = (W - 1 > RFRAC) ? W'(64'd1 << RFRAC) : HI;
    localparam logic signed [ARG_W-1:0] ONE_Q30 = ARG_W'(64'd1 << RFRAC);

    // saturate a divided magnitude with its sign
    function automatic logic [W-1:0] sat_part(logic [W-1:0] q, logic neg);
        logic [W-1:0] v;
        if (neg)
        begin
            v = (q > SIGN_MAG) ? SIGN_MAG : (~q + W'(1));
        end
        else
        begin
            v = (q > HI) ? HI : q;
        end
        return v;
    endfunction

    assign busy = 1'b0;

    // ---------------- ratio dividers ----------------
    logic signed [W-1:0] elem [9];
    logic [W-2:0]        scale [3];
    logic [W-1:0]        emag [9];
    logic                eneg [9];
    logic [RATIO_W-1:0]  rq [9];
    logic [0:0]          rneg [9];
    logic                zero_in;

    assign elem[0] = item.elem_r0c0;
    assign elem[1] = item.elem_r0c1;
    assign elem[2] = item.elem_r0c2;
    assign elem[3] = item.elem_r1c0;
    assign elem[4] = item.elem_r1c1;
    assign elem[5] = item.elem_r1c2;
    assign elem[6] = item.elem_r2c0;
    assign elem[7] = item.elem_r2c1;
    assign elem[8] = item.elem_r2c2;
    assign scale[0] = item.scale_col0;
    assign scale[1] = item.scale_col1;
    assign scale[2] = item.scale_col2;
    assign zero_in = (scale[0] == '0) || (scale[1] == '0) || (scale[2] == '0);

    for (genvar k = 0; k < 9; k++)
    begin : g_ratio
        assign eneg[k] = elem[k][W-1];
        assign emag[k] = eneg[k] ? (~elem[k] + W'(1)) : elem[k];

        smq_divider #(
            .NW    (RAT_NW),
            .DW    (W - 1),
            .QW    (RATIO_W),
            .TAG_W (1)
        ) u_div (
            .clk     (clk),
            .num     ({emag[k], {RFRAC{1'b0}}}),
            .den     (scale[k % 3]),
            .tag_in  (eneg[k]),
            .quo     (rq[k]),
            .tag_out (rneg[k])
        );
    end

    // valid and zero-scale flag beside the ratio dividers
    logic rv_reg [0:RAT_LAT-1];
    logic rz_reg [0:RAT_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RAT_LAT; i++)
            begin
                rv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            rv_reg[0] <= start;
            for (int i = 1; i < RAT_LAT; i++)
            begin
                rv_reg[i] <= rv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rz_reg[0] <= zero_in;
        for (int i = 1; i < RAT_LAT; i++)
        begin
            rz_reg[i] <= rz_reg[i-1];
        end
    end

    // ---------------- B1: signed ratios ----------------
    logic signed [SR_W-1:0] sr_next [9];
    logic signed [SR_W-1:0] sr_reg [9];
    logic                   b1_valid_reg;
    logic                   b1_zero_reg;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            sr_next[k] = rneg[k][0] ? -SR_W'(rq[k]) : SR_W'(rq[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            sr_reg[k] <= sr_next[k];
        end
        b1_zero_reg <= rz_reg[RAT_LAT-1];
    end

    // ---------------- B2: trace, arguments, sums ----------------
    logic signed [ARG_W-1:0] e00, e11, e22, trace;
    logic signed [ARG_W-1:0] arg_next [4];
    logic signed [ARG_W-1:0] arg_reg [4];
    logic signed [NUM_W-1:0] nm_next [6];
    logic signed [NUM_W-1:0] nm_reg [6];
    logic                    tpos_next, tpos_reg;
    logic                    c01_reg, c02_reg, c12_reg;
    logic                    b2_valid_reg;
    logic                    b2_zero_reg;

    always_comb
    begin
        e00   = ARG_W'(sr_reg[0]);
        e11   = ARG_W'(sr_reg[4]);
        e22   = ARG_W'(sr_reg[8]);
        trace = e00 + e11 + e22;
        tpos_next   = (trace > 0);
        arg_next[0] = trace + ONE_Q30;
        arg_next[1] = ONE_Q30 + e00 - e11 - e22;
        arg_next[2] = ONE_Q30 + e11 - e00 - e22;
        arg_next[3] = ONE_Q30 + e22 - e00 - e11;
        // r21-r12, r02-r20, r10-r01, r01+r10, r02+r20, r12+r21
        nm_next[0] = sr_reg[7] - sr_reg[5];
        nm_next[1] = sr_reg[2] - sr_reg[6];
        nm_next[2] = sr_reg[3] - sr_reg[1];
        nm_next[3] = sr_reg[1] + sr_reg[3];
        nm_next[4] = sr_reg[2] + sr_reg[6];
        nm_next[5] = sr_reg[5] + sr_reg[7];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            arg_reg[i] <= arg_next[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            nm_reg[i] <= nm_next[i];
        end
        tpos_reg    <= tpos_next;
        c01_reg     <= (sr_reg[0] > sr_reg[4]);
        c02_reg     <= (sr_reg[0] > sr_reg[8]);
        c12_reg     <= (sr_reg[4] > sr_reg[8]);
        b2_zero_reg <= b1_zero_reg;
    end

    // ---------------- B3: branch select, radicand ----------------
    smq_branch_t             br;
    logic signed [ARG_W-1:0] arg;
    logic                    arg_pos;
    smq_sq_tag_t             sq_tag_next, sq_tag_reg;
    logic [SQ_X_W-1:0]       sq_x_next, sq_x_reg;
    logic                    b3_valid_reg;

    always_comb
    begin
        if (tpos_reg)
        begin
            br = BR_TRACE;
        end
        else if (c01_reg && c02_reg)
        begin
            br = BR_X;
        end
        else if (c12_reg)
        begin
            br = BR_Y;
        end
        else
        begin
            br = BR_Z;
        end

        sq_tag_next.branch = br;
        case (br)
            BR_TRACE:
            begin
                arg            = arg_reg[0];
                sq_tag_next.n0 = nm_reg[0];
                sq_tag_next.n1 = nm_reg[1];
                sq_tag_next.n2 = nm_reg[2];
            end
            BR_X:
            begin
                arg            = arg_reg[1];
                sq_tag_next.n0 = nm_reg[0];
                sq_tag_next.n1 = nm_reg[3];
                sq_tag_next.n2 = nm_reg[4];
            end
            BR_Y:
            begin
                arg            = arg_reg[2];
                sq_tag_next.n0 = nm_reg[1];
                sq_tag_next.n1 = nm_reg[3];
                sq_tag_next.n2 = nm_reg[5];
            end
            default:
            begin
                arg            = arg_reg[3];
                sq_tag_next.n0 = nm_reg[2];
                sq_tag_next.n1 = nm_reg[4];
                sq_tag_next.n2 = nm_reg[5];
            end
        endcase

        arg_pos           = !arg[ARG_W-1] && (arg != '0);
        sq_tag_next.fault = b2_zero_reg || !arg_pos;
        sq_x_next         = arg_pos ? {arg[ARG_MAG_W-1:0], {RFRAC{1'b0}}} : '0;
    end

    always_ff @(posedge clk)
    begin
        sq_tag_reg <= sq_tag_next;
        sq_x_reg   <= sq_x_next;
    end

    // valid through B1..B3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= rv_reg[RAT_LAT-1];
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
        end
    end

    // ---------------- square root cells ----------------
    logic [SQ_X_W-1:0]   sx    [0:ROOT_W];
    logic [SQ_REM_W-1:0] srem  [0:ROOT_W];
    logic [ROOT_W-1:0]   sroot [0:ROOT_W];
    logic [SQ_TW-1:0]    stag  [0:ROOT_W];
    logic                sv_reg [0:ROOT_W-1];
    smq_sq_tag_t         sq_out;
    logic [ROOT_W-1:0]   root;

    assign sx[0]    = sq_x_reg;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign stag[0]  = sq_tag_reg;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        smq_sqrt_cell #(
            .TAG_W (SQ_TW)
        ) u_cell (
            .clk      (clk),
            .x_in     (sx[i]),
            .rem_in   (srem[i]),
            .root_in  (sroot[i]),
            .tag_in   (stag[i]),
            .x_out    (sx[i+1]),
            .rem_out  (srem[i+1]),
            .root_out (sroot[i+1]),
            .tag_out  (stag[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            sv_reg[0] <= b3_valid_reg;
            for (int i = 1; i < ROOT_W; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    assign sq_out = smq_sq_tag_t'(stag[ROOT_W]);
    assign root   = sroot[ROOT_W];

    // ---------------- part dividers ----------------
    logic signed [NUM_W-1:0] pn [3];
    logic                    pneg [3];
    logic [NUM_W-2:0]        pmag [3];
    logic [W-1:0]            pq [3];
    logic [0:0]              pneg_out [3];
    smq_pd_meta_t            pm_next;
    smq_pd_meta_t            pm_reg [0:W];
    logic                    pv_reg [0:W];

    assign pn[0] = sq_out.n0;
    assign pn[1] = sq_out.n1;
    assign pn[2] = sq_out.n2;

    for (genvar l = 0; l < 3; l++)
    begin : g_part
        logic [NUM_W-1:0] nabs;
        assign pneg[l] = pn[l][NUM_W-1];
        assign nabs    = pneg[l] ? (~pn[l] + NUM_W'(1)) : pn[l];
        assign pmag[l] = nabs[NUM_W-2:0];

        smq_divider #(
            .NW    (PD_NW),
            .DW    (ROOT_W),
            .QW    (W),
            .TAG_W (1)
        ) u_div (
            .clk     (clk),
            .num     ({pmag[l], {PFRAC{1'b0}}}),
            .den     (root),
            .tag_in  (pneg[l]),
            .quo     (pq[l]),
            .tag_out (pneg_out[l])
        );
    end

    always_comb
    begin
        pm_next.fault  = sq_out.fault;
        pm_next.branch = sq_out.branch;
        pm_next.half   = root[ROOT_W-1:1];
    end

    always_ff @(posedge clk)
    begin
        pm_reg[0] <= pm_next;
        for (int i = 1; i <= W; i++)
        begin
            pm_reg[i] <= pm_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= W; i++)
            begin
                pv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            pv_reg[0] <= sv_reg[ROOT_W-1];
            for (int i = 1; i <= W; i++)
            begin
                pv_reg[i] <= pv_reg[i-1];
            end
        end
    end

    // ---------------- output stage ----------------
    smq_pd_meta_t pm_out;
    logic [W-1:0] ls [3];
    logic [W-1:0] hs;
    smq_out_t     result_next, result_reg;
    logic         done_reg;

    assign pm_out = pm_reg[W];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            ls[l] = sat_part(pq[l], pneg_out[l][0]);
        end
        hs = (64'(pm_out.half) > 64'(HI)) ? HI : W'(pm_out.half);

        case (pm_out.branch)
            BR_TRACE:
            begin
                result_next.quat_w = hs;
                result_next.quat_x = ls[0];
                result_next.quat_y = ls[1];
                result_next.quat_z = ls[2];
            end
            BR_X:
            begin
                result_next.quat_w = ls[0];
                result_next.quat_x = hs;
                result_next.quat_y = ls[1];
                result_next.quat_z = ls[2];
            end
            BR_Y:
            begin
                result_next.quat_w = ls[0];
                result_next.quat_x = ls[1];
                result_next.quat_y = hs;
                result_next.quat_z = ls[2];
            end
            default:
            begin
                result_next.quat_w = ls[0];
                result_next.quat_x = ls[1];
                result_next.quat_y = ls[2];
                result_next.quat_z = hs;
            end
        endcase
        result_next.fault = pm_out.fault;

        // zero scale or non-positive argument: identity
        if (pm_out.fault)
        begin
            result_next.quat_w = ONE_SAT;
            result_next.quat_x = '0;
            result_next.quat_y = '0;
            result_next.quat_z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pv_reg[W];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- assertions ----------------
    `SMQ_IMPLY(a_fault_identity, done && result.fault, (result.quat_w == ONE_SAT) && (result.quat_x == '0) && (result.quat_y == '0) && (result.quat_z == '0), "fault result is not the identity")
    `SMQ_IMPLY(a_root_nonzero, sv_reg[ROOT_W-1] && !sq_out.fault, root != '0, "zero root without fault")
    `SMQ_NEVER(a_radicand_fault, b3_valid_reg && !sq_tag_reg.fault && (sq_x_reg == '0), "empty radicand without fault")

endmodule
